FILE: sv/bpa_pkg.sv
// Shared types, codes and defaults of the buddy page allocator.
package bpa_pkg;

  localparam int unsigned BPA_MAX_ORDER = 13;
  localparam int unsigned BPA_PAGES     = 4096;
  localparam int unsigned CFG_W         = 13;
  localparam int unsigned ORD_IN_W      = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_INIT  = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NOMEM   = 2'd1,
    STS_ORDER   = 2'd2,
    STS_INVALID = 2'd3
  } sts_e;

  typedef enum logic [4:0] {
    U_NOP,
    U_LOAD,
    U_INIT_START,
    U_CLR,
    U_SET_ORDER,
    U_SET_NOMEM,
    U_SET_INV,
    U_APICK,
    U_FRD,
    U_FREL,
    U_UL,
    U_SPDEC,
    U_P1,
    U_P2,
    U_AFIN,
    U_PFIN,
    U_MRD,
    U_LRD,
    U_MUP,
    U_INIT_PG,
    U_EMIT
  } uop_e;

  typedef struct packed {
    req_e req;
    logic ord_big;
    logic any_free;
    logic clr_last;
    logic init_more;
    logic fchk_bad;
    logic split_done;
    logic bok;
    logic m_stop;
    logic m_ok;
    logic out_free;
  } bpa_stat_t;

endpackage

FILE: sv/bpa_if.sv
// Request and response channel interfaces of the buddy page allocator.
interface bpa_req_if #(
  parameter int unsigned PW = 12
);
  logic          valid;
  logic          ready;
  logic [1:0]    req_type;
  logic [3:0]    order;
  logic [PW-1:0] page_index;

  modport source (output valid, output req_type, output order, output page_index,
                  input ready);
  modport sink (input valid, input req_type, input order, input page_index,
                output ready);
endinterface

interface bpa_rsp_if #(
  parameter int unsigned PW = 12,
  parameter int unsigned FW = 13
);
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [PW-1:0] granted_page;
  logic [FW-1:0] free_pages;

  modport source (output valid, output status, output granted_page, output free_pages,
                  input ready);
  modport sink (input valid, input status, input granted_page, input free_pages,
                output ready);
endinterface

FILE: sv/buddy_page_allocator.sv
// Top level of the buddy page allocator: sequencer plus datapath.
//
//   channel   direction  carries
//   req_i     in         req_type, order, page_index
//   rsp_o     out        status, granted_page, free_pages
//   cfg       in         cfg_we_i, cfg_wdata_i (pool_pages)
//
// One request at a time: a new request is taken only in idle, once the last result is emitted.
// Alloc ends at once on order too large or no memory, else unlinks a block and splits it down;
// free ends as invalid or merges with free buddies; init sweeps the tables, then frees each
// pool page. Walks are bounded by MAX_ORDER levels on single-port page tables. After reset a
// sweep over all PAGES entries clears the order, free and alloc tables; no request is taken
// meanwhile. A finished result waits in the output register while rsp_o stalls.
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int unsigned MAX_ORDER = BPA_MAX_ORDER,
  parameter int unsigned PAGES     = BPA_PAGES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bpa_req_if.sink          req_i,
  bpa_rsp_if.source        rsp_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  bpa_stat_t stat;
  uop_e      cmd;

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bpa_dp #(
    .MAX_ORDER (MAX_ORDER),
    .PAGES     (PAGES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_req_type_i      (req_i.req_type),
    .in_order_i         (req_i.order),
    .in_page_index_i    (req_i.page_index),
    .out_valid_o        (rsp_o.valid),
    .out_ready_i        (rsp_o.ready),
    .out_status_o       (rsp_o.status),
    .out_granted_page_o (rsp_o.granted_page),
    .out_free_pages_o   (rsp_o.free_pages)
  );

endmodule

FILE: sv/bpa_ctrl.sv
// Sequencer of the buddy page allocator: steps through alloc, free and init.
module bpa_ctrl import bpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bpa_stat_t stat_i,
  output uop_e      cmd_o
);

  typedef enum logic [13:0] {
    S_CLR   = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_DISP  = 14'b00000000000100,
    S_FCHK  = 14'b00000000001000,
    S_UL2   = 14'b00000000010000,
    S_SP0   = 14'b00000000100000,
    S_SP1   = 14'b00000001000000,
    S_P1    = 14'b00000010000000,
    S_P2    = 14'b00000100000000,
    S_M0    = 14'b00001000000000,
    S_M1    = 14'b00010000000000,
    S_MUP   = 14'b00100000000000,
    S_INEXT = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_e;

  typedef enum logic [1:0] {
    MODE_ALLOC,
    MODE_FREE,
    MODE_INIT
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cmd_o   = U_NOP;
    unique case (state_q)
      S_CLR: begin
        cmd_o = U_CLR;
        if (stat_i.clr_last) begin
          state_d = (mode_q == MODE_INIT) ? S_INEXT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = U_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.req)
          REQ_ALLOC: begin
            mode_d = MODE_ALLOC;
            if (stat_i.ord_big) begin
              cmd_o   = U_SET_ORDER;
              state_d = S_FIN;
            end else if (!stat_i.any_free) begin
              cmd_o   = U_SET_NOMEM;
              state_d = S_FIN;
            end else begin
              cmd_o   = U_APICK;
              state_d = S_UL2;
            end
          end
          REQ_FREE: begin
            mode_d  = MODE_FREE;
            cmd_o   = U_FRD;
            state_d = S_FCHK;
          end
          REQ_INIT: begin
            mode_d  = MODE_INIT;
            cmd_o   = U_INIT_START;
            state_d = S_CLR;
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_FCHK: begin
        if (stat_i.fchk_bad) begin
          cmd_o   = U_SET_INV;
          state_d = S_FIN;
        end else begin
          cmd_o   = U_FREL;
          state_d = S_M0;
        end
      end
      S_UL2: begin
        cmd_o   = U_UL;
        state_d = (mode_q == MODE_ALLOC) ? S_SP0 : S_MUP;
      end
      S_SP0: begin
        if (stat_i.split_done) begin
          cmd_o   = U_AFIN;
          state_d = S_FIN;
        end else begin
          cmd_o   = U_SPDEC;
          state_d = S_SP1;
        end
      end
      S_SP1: begin
        if (stat_i.bok) begin
          cmd_o   = U_P1;
          state_d = S_P2;
        end else begin
          state_d = S_SP0;
        end
      end
      S_P1: begin
        cmd_o   = U_P1;
        state_d = S_P2;
      end
      S_P2: begin
        cmd_o = U_P2;
        unique case (mode_q)
          MODE_ALLOC: state_d = S_SP0;
          MODE_INIT:  state_d = S_INEXT;
          default:    state_d = S_FIN;
        endcase
      end
      S_M0: begin
        if (stat_i.m_stop) begin
          cmd_o   = U_PFIN;
          state_d = S_P1;
        end else begin
          cmd_o   = U_MRD;
          state_d = S_M1;
        end
      end
      S_M1: begin
        if (stat_i.m_ok) begin
          cmd_o   = U_LRD;
          state_d = S_UL2;
        end else begin
          cmd_o   = U_PFIN;
          state_d = S_P1;
        end
      end
      S_MUP: begin
        cmd_o   = U_MUP;
        state_d = S_M0;
      end
      S_INEXT: begin
        if (stat_i.init_more) begin
          cmd_o   = U_INIT_PG;
          state_d = S_M0;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o   = U_EMIT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      mode_q  <= MODE_FREE;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

FILE: sv/bpa_dp.sv
// Datapath of the buddy page allocator: page tables, list heads, counters.
module bpa_dp import bpa_pkg::*; #(
  parameter int unsigned MAX_ORDER = BPA_MAX_ORDER,
  parameter int unsigned PAGES     = BPA_PAGES,
  localparam int unsigned PW = (PAGES > 1) ? $clog2(PAGES) : 1,
  localparam int unsigned FW = $clog2(PAGES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  uop_e                cmd_i,
  output bpa_stat_t           stat_o,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic [1:0]          in_req_type_i,
  input  logic [ORD_IN_W-1:0] in_order_i,
  input  logic [PW-1:0]       in_page_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          out_status_o,
  output logic [PW-1:0]       out_granted_page_o,
  output logic [FW-1:0]       out_free_pages_o
);

  localparam int unsigned LW  = PW + 1;
  localparam int unsigned OW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int unsigned SW  = (FW > CFG_W) ? FW : CFG_W;
  localparam int unsigned MW  = ((PW > MAX_ORDER) ? PW : MAX_ORDER) + 1;
  localparam int unsigned AW  = ((MW > SW) ? MW : SW) + 1;
  localparam logic [LW-1:0] LINK_NULL = {1'b1, {PW{1'b0}}};

  // page tables
  logic [OW-1:0] ord_mem   [PAGES];
  logic          free_mem  [PAGES];
  logic          alloc_mem [PAGES];
  logic [LW-1:0] nxt_mem   [PAGES];
  logic [LW-1:0] prv_mem   [PAGES];

  logic [PW-1:0] ord_a, free_a, alloc_a, nxt_a, prv_a;
  logic          ord_we, free_we, alloc_we, nxt_we, prv_we;
  logic [OW-1:0] ord_wd;
  logic          free_wd, alloc_wd;
  logic [LW-1:0] nxt_wd, prv_wd;
  logic [OW-1:0] ord_rd_q;
  logic          free_rd_q, alloc_rd_q;
  logic [LW-1:0] nxt_rd_q, prv_rd_q;

  // control registers
  logic [LW-1:0]    first_q [MAX_ORDER];
  logic [FW-1:0]    tot_q;
  logic [PW:0]      cnt_q;
  logic             out_valid_q;
  logic [CFG_W-1:0] cfg_q;

  // payload registers
  logic [1:0]    req_q;
  logic          ord_big_q;
  logic [OW-1:0] tgt_q, o_q;
  logic [PW-1:0] p_q, b_q;
  logic [LW-1:0] n_q;
  logic          bok_q;
  logic [1:0]    sts_q;
  logic [PW-1:0] gnt_q;
  logic [1:0]    out_sts_q;
  logic [PW-1:0] out_gnt_q;
  logic [FW-1:0] out_tot_q;

  logic [SW-1:0] pool_sz;
  logic          any_free;
  logic [OW-1:0] cur;
  logic [AW-1:0] sz, bx, spsum;
  logic [OW-1:0] o_dn;
  logic [LW-1:0] first_cur, first_o;

  assign pool_sz = (SW'(cfg_q) > SW'(PAGES)) ? SW'(PAGES) : SW'(cfg_q);

  always_comb begin
    any_free = 1'b0;
    cur      = '0;
    for (int i = MAX_ORDER - 1; i >= 0; i--) begin
      if (!first_q[i][PW] && (i >= int'(tgt_q))) begin
        any_free = 1'b1;
        cur      = OW'(i);
      end
    end
  end

  assign first_cur = first_q[cur];
  assign first_o   = first_q[o_q];
  assign sz        = AW'(1) << o_q;
  assign bx        = AW'(p_q) ^ sz;
  assign o_dn      = o_q - OW'(1);
  assign spsum     = AW'(p_q) + (AW'(1) << o_dn);

  always_comb begin
    stat_o.req        = req_e'(req_q);
    stat_o.ord_big    = ord_big_q;
    stat_o.any_free   = any_free;
    stat_o.clr_last   = (cnt_q[PW-1:0] == PW'(PAGES - 1));
    stat_o.init_more  = (AW'(cnt_q) < AW'(pool_sz));
    stat_o.fchk_bad   = (AW'(p_q) >= AW'(pool_sz)) || !alloc_rd_q;
    stat_o.split_done = (o_q == tgt_q);
    stat_o.bok        = bok_q;
    stat_o.m_stop     = (({1'b0, o_q} + (OW+1)'(1)) >= (OW+1)'(MAX_ORDER)) ||
                        ((bx + sz) > AW'(pool_sz));
    stat_o.m_ok       = free_rd_q && (ord_rd_q == o_q);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // table port control
  always_comb begin
    ord_a    = p_q;
    free_a   = b_q;
    alloc_a  = p_q;
    nxt_a    = b_q;
    prv_a    = b_q;
    ord_we   = 1'b0;
    free_we  = 1'b0;
    alloc_we = 1'b0;
    nxt_we   = 1'b0;
    prv_we   = 1'b0;
    ord_wd   = o_q;
    free_wd  = 1'b0;
    alloc_wd = 1'b0;
    nxt_wd   = first_o;
    prv_wd   = LINK_NULL;
    unique case (cmd_i)
      U_CLR: begin
        ord_a    = cnt_q[PW-1:0];
        free_a   = cnt_q[PW-1:0];
        alloc_a  = cnt_q[PW-1:0];
        ord_we   = 1'b1;
        free_we  = 1'b1;
        alloc_we = 1'b1;
        ord_wd   = '0;
      end
      U_APICK: begin
        nxt_a = first_cur[PW-1:0];
        prv_a = first_cur[PW-1:0];
      end
      U_UL: begin
        free_a  = b_q;
        free_we = 1'b1;
        nxt_a   = prv_rd_q[PW-1:0];
        nxt_we  = !prv_rd_q[PW];
        nxt_wd  = nxt_rd_q;
        prv_a   = nxt_rd_q[PW-1:0];
        prv_we  = !nxt_rd_q[PW];
        prv_wd  = prv_rd_q;
      end
      U_P1: begin
        ord_a   = b_q;
        ord_we  = 1'b1;
        ord_wd  = o_q;
        free_a  = b_q;
        free_we = 1'b1;
        free_wd = 1'b1;
        nxt_a   = b_q;
        nxt_we  = 1'b1;
        nxt_wd  = first_o;
        prv_a   = b_q;
        prv_we  = 1'b1;
        prv_wd  = LINK_NULL;
      end
      U_P2: begin
        prv_a  = n_q[PW-1:0];
        prv_we = !n_q[PW];
        prv_wd = {1'b0, b_q};
      end
      U_AFIN: begin
        ord_a    = p_q;
        ord_we   = 1'b1;
        ord_wd   = tgt_q;
        alloc_a  = p_q;
        alloc_we = 1'b1;
        alloc_wd = 1'b1;
      end
      U_FREL: begin
        alloc_a  = p_q;
        alloc_we = 1'b1;
        alloc_wd = 1'b0;
      end
      U_MRD: begin
        ord_a  = bx[PW-1:0];
        free_a = bx[PW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_a] <= ord_wd;
    end
    ord_rd_q <= ord_mem[ord_a];
  end

  always_ff @(posedge clk_i) begin
    if (free_we) begin
      free_mem[free_a] <= free_wd;
    end
    free_rd_q <= free_mem[free_a];
  end

  always_ff @(posedge clk_i) begin
    if (alloc_we) begin
      alloc_mem[alloc_a] <= alloc_wd;
    end
    alloc_rd_q <= alloc_mem[alloc_a];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[nxt_a] <= nxt_wd;
    end
    nxt_rd_q <= nxt_mem[nxt_a];
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) begin
      prv_mem[prv_a] <= prv_wd;
    end
    prv_rd_q <= prv_mem[prv_a];
  end

  // list heads, free total, sweep counter, result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        first_q[i] <= LINK_NULL;
      end
      tot_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      cfg_q       <= CFG_RESET;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i == U_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i)
        U_INIT_START: begin
          for (int i = 0; i < MAX_ORDER; i++) begin
            first_q[i] <= LINK_NULL;
          end
          tot_q <= '0;
          cnt_q <= '0;
        end
        U_CLR: begin
          cnt_q <= stat_o.clr_last ? '0 : cnt_q + (PW+1)'(1);
        end
        U_APICK: begin
          tot_q <= tot_q - FW'(AW'(1) << cur);
        end
        U_SPDEC: begin
          if (spsum < AW'(PAGES)) begin
            tot_q <= tot_q + FW'(AW'(1) << o_dn);
          end
        end
        U_UL: begin
          if (prv_rd_q[PW]) begin
            first_q[o_q] <= nxt_rd_q;
          end
        end
        U_P1: begin
          first_q[o_q] <= {1'b0, b_q};
        end
        U_FREL: begin
          tot_q <= tot_q + FW'(AW'(1) << ord_rd_q);
        end
        U_INIT_PG: begin
          tot_q <= tot_q + FW'(1);
          cnt_q <= cnt_q + (PW+1)'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      U_LOAD: begin
        req_q     <= in_req_type_i;
        ord_big_q <= ({1'b0, in_order_i} >= (ORD_IN_W+1)'(MAX_ORDER));
        tgt_q     <= OW'(in_order_i);
        p_q       <= in_page_index_i;
        sts_q     <= STS_OK;
        gnt_q     <= '0;
      end
      U_SET_ORDER: sts_q <= STS_ORDER;
      U_SET_NOMEM: sts_q <= STS_NOMEM;
      U_SET_INV:   sts_q <= STS_INVALID;
      U_APICK: begin
        o_q <= cur;
        p_q <= first_cur[PW-1:0];
        b_q <= first_cur[PW-1:0];
      end
      U_SPDEC: begin
        o_q   <= o_dn;
        b_q   <= spsum[PW-1:0];
        bok_q <= (spsum < AW'(PAGES));
      end
      U_P1: begin
        n_q <= first_o;
      end
      U_AFIN: begin
        gnt_q <= p_q;
      end
      U_FREL: begin
        o_q <= ord_rd_q;
      end
      U_PFIN: begin
        b_q <= p_q;
      end
      U_MRD: begin
        b_q <= bx[PW-1:0];
      end
      U_MUP: begin
        if (b_q < p_q) begin
          p_q <= b_q;
        end
        o_q <= o_q + OW'(1);
      end
      U_INIT_PG: begin
        p_q <= cnt_q[PW-1:0];
        o_q <= '0;
      end
      U_EMIT: begin
        out_sts_q <= sts_q;
        out_gnt_q <= gnt_q;
        out_tot_q <= tot_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_sts_q;
  assign out_granted_page_o = out_gnt_q;
  assign out_free_pages_o   = out_tot_q;

endmodule

FILE: test/buddy_page_allocator_tb.sv
// Self-checking testbench of the buddy page allocator: random and directed requests.
module buddy_page_allocator_tb;
  import bpa_pkg::*;

  localparam int NPG       = BPA_PAGES;
  localparam int NORD      = BPA_MAX_ORDER;
  localparam int NIL       = -1;
  localparam int WDOG_MAX  = 300000;
  localparam int END_WAIT  = 200;

  typedef enum logic [1:0] {K_REQ, K_CFG, K_DRAIN} kind_e;

  typedef struct {
    kind_e       kind;
    req_e        req;
    logic [3:0]  ord;
    logic [11:0] pg;
    bit          live;
    logic [12:0] cfg;
  } op_t;

  typedef struct {
    sts_e        sts;
    logic [11:0] page;
    logic [12:0] nfree;
  } rsp_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  bpa_req_if req_if ();
  bpa_rsp_if rsp_if ();

  buddy_page_allocator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // allocator shadow state
  logic [12:0] pool_reg;
  int          blk_ord [NPG];
  bit          free_hd [NPG];
  bit          used_hd [NPG];
  int          nxt [NPG];
  int          prv [NPG];
  int          head [NORD];
  int          cnt [NORD];
  int          free_total;
  int          live_pages[$];

  op_t  pending_ops[$];
  rsp_t resp_q[$];
  int   n_err;
  int   n_cyc;
  int   idle_cyc;
  int   n_req;

  function automatic int pool_eff();
    return (pool_reg > NPG) ? NPG : int'(pool_reg);
  endfunction

  function automatic void push_head(int o, int p);
    prv[p] = NIL;
    nxt[p] = head[o];
    if (head[o] != NIL) prv[head[o]] = p;
    head[o] = p;
    cnt[o]++;
    blk_ord[p] = o;
    free_hd[p] = 1;
  endfunction

  function automatic void unlink_entry(int o, int p);
    int n;
    int v;
    n = nxt[p];
    v = prv[p];
    if (v != NIL && v < NPG) nxt[v] = n;
    else head[o] = n;
    if (n != NIL && n < NPG) prv[n] = v;
    if (cnt[o] > 0) cnt[o]--;
    free_hd[p] = 0;
  endfunction

  function automatic void drop_live(int p);
    foreach (live_pages[i]) begin
      if (live_pages[i] == p) begin
        live_pages.delete(i);
        return;
      end
    end
  endfunction

  function automatic void merge_free(int p);
    int o;
    int sz;
    int b;
    o = blk_ord[p];
    used_hd[p] = 0;
    drop_live(p);
    free_total += 1 << o;
    while (o + 1 < NORD) begin
      sz = 1 << o;
      b = p ^ sz;
      if (b + sz > pool_eff()) break;
      if (!free_hd[b] || blk_ord[b] != o) break;
      unlink_entry(o, b);
      if (b < p) p = b;
      o++;
    end
    push_head(o, p);
  endfunction

  function automatic void clear_state();
    for (int i = 0; i < NPG; i++) begin
      blk_ord[i] = 0;
      free_hd[i] = 0;
      used_hd[i] = 0;
      nxt[i] = 0;
      prv[i] = 0;
    end
    for (int i = 0; i < NORD; i++) begin
      head[i] = NIL;
      cnt[i] = 0;
    end
    free_total = 0;
    live_pages.delete();
  endfunction

  function automatic rsp_t calc_response(req_e rq, logic [3:0] ord, logic [11:0] pg);
    rsp_t r;
    int cur;
    int p;
    int b;
    r.sts = STS_OK;
    r.page = '0;
    case (rq)
      REQ_ALLOC: begin
        if (int'(ord) >= NORD) begin
          r.sts = STS_ORDER;
        end else begin
          cur = int'(ord);
          while (cur < NORD && head[cur] == NIL) cur++;
          if (cur >= NORD) begin
            r.sts = STS_NOMEM;
          end else begin
            p = head[cur];
            unlink_entry(cur, p);
            free_total -= 1 << cur;
            while (cur > int'(ord)) begin
              cur--;
              b = p + (1 << cur);
              if (b < NPG) begin
                push_head(cur, b);
                free_total += 1 << cur;
              end
            end
            blk_ord[p] = int'(ord);
            used_hd[p] = 1;
            live_pages.push_back(p);
            r.page = p[11:0];
          end
        end
      end
      REQ_FREE: begin
        if (int'(pg) >= pool_eff() || !used_hd[pg]) r.sts = STS_INVALID;
        else merge_free(int'(pg));
      end
      REQ_INIT: begin
        clear_state();
        for (int i = 0; i < pool_eff(); i++) begin
          blk_ord[i] = 0;
          used_hd[i] = 1;
          merge_free(i);
        end
      end
      default: ;
    endcase
    r.nfree = free_total[12:0];
    return r;
  endfunction

  function automatic bit no_idle();
    return (n_cyc % 5000) < 800;
  endfunction

  // request driver
  always @(posedge clk) begin
    op_t  op;
    logic nv;
    logic nwe;
    int   pick;
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        resp_q.push_back(calc_response(req_e'(req_if.req_type), req_if.order,
                                       req_if.page_index));
        n_req++;
        nv = 1'b0;
      end else begin
        nv = req_if.valid;
      end
      nwe = 1'b0;
      if (!nv && pending_ops.size() > 0) begin
        op = pending_ops[0];
        if (op.kind != K_REQ) begin
          if (resp_q.size() == 0) begin
            void'(pending_ops.pop_front());
            if (op.kind == K_CFG) begin
              nwe = 1'b1;
              cfg_wdata <= op.cfg;
              pool_reg = op.cfg;
            end
          end
        end else if (no_idle() || $urandom_range(99) >= 32) begin
          void'(pending_ops.pop_front());
          if (op.live && live_pages.size() > 0) begin
            pick = live_pages[$urandom_range(live_pages.size() - 1)];
            op.pg = pick[11:0];
          end
          nv = 1'b1;
          req_if.req_type   <= op.req;
          req_if.order      <= op.ord;
          req_if.page_index <= op.pg;
        end
      end
      req_if.valid <= nv;
      cfg_we <= nwe;
    end
  end

  // response monitor
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n) begin
      n_cyc++;
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cyc = 0;
      else idle_cyc++;
      if (rsp_if.valid && rsp_if.ready) begin
        if (resp_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected response status=%0d", rsp_if.status);
        end else begin
          want = resp_q.pop_front();
          if (rsp_if.status !== want.sts || rsp_if.granted_page !== want.page ||
              rsp_if.free_pages !== want.nfree) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: exp sts=%0d page=%0d free=%0d got sts=%0d page=%0d free=%0d",
                       want.sts, want.page, want.nfree, rsp_if.status,
                       rsp_if.granted_page, rsp_if.free_pages);
          end
        end
      end
      rsp_if.ready <= no_idle() || ($urandom_range(99) >= 32);
      if (idle_cyc >= WDOG_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic add_req(req_e rq, int ord, int pg, bit live = 0);
    op_t op;
    op.kind = K_REQ;
    op.req = rq;
    op.ord = ord[3:0];
    op.pg = pg[11:0];
    op.live = live;
    op.cfg = '0;
    pending_ops.push_back(op);
  endtask

  task automatic add_ctl(kind_e k, int val = 0);
    op_t op;
    op.kind = k;
    op.req = REQ_NOP;
    op.ord = '0;
    op.pg = '0;
    op.live = 0;
    op.cfg = val[12:0];
    pending_ops.push_back(op);
  endtask

  initial begin
    int total;
    int sel;
    int pool;
    int len;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_NOP;
    req_if.order = '0;
    req_if.page_index = '0;
    rsp_if.ready = 1'b0;
    n_err = 0;
    n_cyc = 0;
    idle_cyc = 0;
    n_req = 0;
    pool_reg = CFG_RESET;
    clear_state();

    // before any init
    add_req(REQ_ALLOC, 0, 0);
    add_req(REQ_FREE, 0, 0);
    add_req(REQ_NOP, 15, 4095);
    add_req(REQ_ALLOC, 13, 0);
    add_req(REQ_ALLOC, 15, 0);
    add_ctl(K_CFG, 16);
    add_req(REQ_INIT, 0, 0);
    add_req(REQ_ALLOC, 0, 0);
    add_req(REQ_ALLOC, 3, 0);
    add_req(REQ_ALLOC, 4, 0);
    add_req(REQ_FREE, 0, 15);
    add_req(REQ_FREE, 0, 4095);
    add_req(REQ_FREE, 0, 0);
    add_req(REQ_FREE, 0, 0, 1);
    add_req(REQ_ALLOC, 12, 0);
    add_ctl(K_CFG, 0);
    add_req(REQ_INIT, 0, 0);
    add_req(REQ_ALLOC, 0, 0);
    add_ctl(K_CFG, 8191);
    add_req(REQ_INIT, 0, 0);
    add_req(REQ_ALLOC, 12, 0);
    add_req(REQ_ALLOC, 12, 0);
    add_ctl(K_CFG, 3);
    add_req(REQ_FREE, 0, 2048);
    add_req(REQ_FREE, 0, 0, 1);
    add_ctl(K_CFG, 4096);
    add_req(REQ_FREE, 0, 0, 1);
    add_req(REQ_NOP, 0, 0);

    total = 0;
    while (total < 650) begin
      sel = $urandom_range(19);
      if (sel == 0) pool = 4096;
      else if (sel == 1) pool = 4095 + $urandom_range(4096);
      else if (sel == 2) pool = $urandom_range(1);
      else if (sel < 5) pool = $urandom_range(2, 300);
      else pool = $urandom_range(1, 64);
      add_ctl(K_CFG, pool);
      add_req(REQ_INIT, 0, 0);
      len = $urandom_range(20, 60);
      for (int i = 0; i < len; i++) begin
        sel = $urandom_range(99);
        if (sel < 42) add_req(REQ_ALLOC, ($urandom_range(9) == 0) ? $urandom_range(15)
                                                                 : $urandom_range(4), 0);
        else if (sel < 82) add_req(REQ_FREE, 0, 0, 1);
        else if (sel < 92) add_req(REQ_FREE, $urandom_range(15), $urandom_range(4095));
        else if (sel < 96) add_req(REQ_NOP, $urandom_range(15), $urandom_range(4095));
        else if (sel < 98) add_ctl(K_DRAIN);
        else add_ctl(K_CFG, $urandom_range(1, 64));
      end
      total += len + 1;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_ops.size() == 0 && !req_if.valid && resp_q.size() == 0);
    repeat (END_WAIT) @(posedge clk);
    if (n_err == 0 && resp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/bpa_pkg.sv
sv/bpa_if.sv
sv/bpa_ctrl.sv
sv/bpa_dp.sv
sv/buddy_page_allocator.sv
test/buddy_page_allocator_tb.sv
